// ===== src/tfn_pkg.sv =====
// shared constants for the triangle face normal pipeline
package tfn_pkg;

  // default coordinate width and normal fraction width
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // fixed field widths of the stream payload
  localparam int FIELD_W    = 16;
  localparam int IN_FIELDS  = 9;
  localparam int OUT_FIELDS = 3;
  localparam int IN_DATA_W  = FIELD_W * IN_FIELDS;
  localparam int OUT_DATA_W = FIELD_W * OUT_FIELDS;

  // magnitudes are brought below 2^M_BITS before squaring
  localparam int M_BITS = 30;

endpackage

// ===== src/tfn_cross.sv =====
// edge vectors and exact cross product, three register stages
module tfn_cross #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic [2:0]                        ld,
  input  logic [tfn_pkg::IN_DATA_W-1:0]     in_data,
  output logic signed [2*COORD_BITS+1:0]    n_out [3]
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 1;
  localparam int PW = 2 * CB + 1;
  localparam int NW = 2 * CB + 2;
  localparam int FW = tfn_pkg::FIELD_W;
  localparam int XW = (CB > FW) ? CB : FW;

  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [PW-1:0] p_r  [6];
  logic signed [NW-1:0] n_r  [3];
  logic signed [CB-1:0] crd  [9];

  // low coordinate bits of each field, sign taken from the top one
  function automatic logic signed [CB-1:0] coord(input logic [FW-1:0] f);
    logic [XW-1:0] w;
    w = XW'(f);
    return $signed(w[CB-1:0]);
  endfunction

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = coord(in_data[i*FW +: FW]);
    end
  end

  // stage 1: edges b-a and c-b
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(crd[3+i]) - EW'(crd[i]);
        e2_r[i] <= EW'(crd[6+i]) - EW'(crd[3+i]);
      end
    end
  end

  // stage 2: the six partial products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p_r[0] <= PW'(e1_r[1]) * PW'(e2_r[2]);
      p_r[1] <= PW'(e1_r[2]) * PW'(e2_r[1]);
      p_r[2] <= PW'(e1_r[2]) * PW'(e2_r[0]);
      p_r[3] <= PW'(e1_r[0]) * PW'(e2_r[2]);
      p_r[4] <= PW'(e1_r[0]) * PW'(e2_r[1]);
      p_r[5] <= PW'(e1_r[1]) * PW'(e2_r[0]);
    end
  end

  // stage 3: cross product components
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(p_r[2*i]) - NW'(p_r[2*i+1]);
      end
    end
  end

  assign n_out = n_r;

endmodule

// ===== src/tfn_norm.sv =====
// magnitude, range shift, squares and squared length, four register stages
module tfn_norm #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic [3:0]                             ld,
  input  logic signed [2*COORD_BITS+1:0]         n_in [3],
  output logic [2*tfn_pkg::M_BITS+1:0]           s_out,
  output logic [2*tfn_pkg::M_BITS-1:0]           sq_out [3],
  output logic [2:0]                             neg_out,
  output logic                                   degen_out
);

  localparam int NW  = 2 * COORD_BITS + 2;
  localparam int MGW = NW - 1;
  localparam int MB  = tfn_pkg::M_BITS;
  localparam int MXW = (MGW > MB) ? MGW : MB;
  localparam int KW  = $clog2(MXW + 1);
  localparam int SQW = 2 * MB;
  localparam int SW  = 2 * MB + 2;

  logic [MGW-1:0] mag   [3];
  logic [MXW-1:0] mag_or;
  logic [KW-1:0]  k_nxt;

  logic [MGW-1:0] mag_r [3];
  logic [KW-1:0]  k_r;
  logic [2:0]     neg4_r, neg5_r, neg6_r, neg7_r;
  logic           dg4_r, dg5_r, dg6_r, dg7_r;
  logic [MB-1:0]  m_r   [3];
  logic [SQW-1:0] sq6_r [3];
  logic [SQW-1:0] sq7_r [3];
  logic [SW-1:0]  s_r;

  // absolute values and the shift that brings all three below 2^MB
  always_comb begin
    logic signed [NW-1:0] ab;
    for (int i = 0; i < 3; i++) begin
      ab     = n_in[i][NW-1] ? -n_in[i] : n_in[i];
      mag[i] = ab[MGW-1:0];
    end
    mag_or = MXW'(mag[0] | mag[1] | mag[2]);
    k_nxt  = '0;
    for (int j = MB; j < MXW; j++) begin
      if (mag_or[j]) begin
        k_nxt = KW'(j - MB + 1);
      end
    end
  end

  // stage 4: magnitudes, signs, shift amount
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= mag[i];
        neg4_r[i] <= n_in[i][NW-1];
      end
      k_r   <= k_nxt;
      dg4_r <= (mag_or == '0);
    end
  end

  // stage 5: truncating right shift
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= MB'(MXW'(mag_r[i]) >> k_r);
      end
      neg5_r <= neg4_r;
      dg5_r  <= dg4_r;
    end
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= SQW'(m_r[i]) * SQW'(m_r[i]);
      end
      neg6_r <= neg5_r;
      dg6_r  <= dg5_r;
    end
  end

  // stage 7: squared length
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s_r    <= SW'(sq6_r[0]) + SW'(sq6_r[1]) + SW'(sq6_r[2]);
      sq7_r  <= sq6_r;
      neg7_r <= neg6_r;
      dg7_r  <= dg6_r;
    end
  end

  assign s_out     = s_r;
  assign sq_out    = sq7_r;
  assign neg_out   = neg7_r;
  assign degen_out = dg7_r;

endmodule

// ===== src/tfn_root_step.sv =====
// one bit of the rounded quotient m*2^F/sqrt(s) for all three lanes
module tfn_root_step #(
  parameter int FRAC_BITS = tfn_pkg::FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                                  clk,
  input  logic                                  ld,
  input  logic [2*tfn_pkg::M_BITS+1:0]          s_in,
  input  logic signed [2*FRAC_BITS+66:0]        r_in   [3],
  input  logic signed [2*FRAC_BITS+66:0]        d_in   [3],
  input  logic signed [2*FRAC_BITS+66:0]        p_in   [3],
  input  logic [FRAC_BITS:0]                    q_in   [3],
  input  logic [2:0]                            neg_in,
  input  logic                                  degen_in,
  output logic [2*tfn_pkg::M_BITS+1:0]          s_out,
  output logic signed [2*FRAC_BITS+66:0]        r_out  [3],
  output logic signed [2*FRAC_BITS+66:0]        d_out  [3],
  output logic signed [2*FRAC_BITS+66:0]        p_out  [3],
  output logic [FRAC_BITS:0]                    q_out  [3],
  output logic [2:0]                            neg_out,
  output logic                                  degen_out
);

  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * F + 67;
  localparam int QW = F + 1;

  logic signed [DW-1:0] s_ext;
  logic signed [DW-1:0] dt [3];
  logic [2:0]           ok;

  // d = 2q-1, with d^2*s and d*s kept by shifts and adds
  always_comb begin
    s_ext = $signed(DW'(s_in));
    for (int i = 0; i < 3; i++) begin
      dt[i] = d_in[i] + (p_in[i] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
      ok[i] = !q_in[i][F] && (dt[i] <= r_in[i]);
    end
  end

  // take the bit when (2t-1)^2*s stays within 4*m^2*2^(2F)
  always_ff @(posedge clk) begin
    if (ld) begin
      for (int i = 0; i < 3; i++) begin
        d_out[i] <= ok[i] ? dt[i] : d_in[i];
        p_out[i] <= ok[i] ? p_in[i] + (s_ext <<< (BIT + 1)) : p_in[i];
        q_out[i] <= ok[i] ? (q_in[i] | (QW'(1) << BIT)) : q_in[i];
      end
      s_out     <= s_in;
      r_out     <= r_in;
      neg_out   <= neg_in;
      degen_out <= degen_in;
    end
  end

endmodule

// ===== src/triangle_face_normal_core.sv =====
// top level of the triangle unit face normal pipeline
//
// One triangle per input beat: in_tdata carries a_x..c_z, nine signed Q8.8
// words of 16 bits. One result beat per triangle: out_tdata carries the unit
// normal x, y, z in signed Q1.NORMAL_FRAC_BITS, out_tuser[0] flags a
// degenerate triangle (zero cross product), in which case the normal is zero.
// The stages are three for edges and cross product, four for magnitude,
// shift, squares and length, one per quotient bit (NORMAL_FRAC_BITS + 1 of
// them) and the output register. Throughput is one triangle per cycle while
// the receiver does not stall; the quotient bit stages set the depth.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves on, so bubbles close up and in_tready stays high
// while the output waits, until the pipe is full. When the receiver stalls
// nothing is lost or repeated. Reset clears all valid bits; data registers
// are not reset.
module triangle_face_normal_core #(
  parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [tfn_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // normal_x, normal_y, normal_z
  output logic [tfn_pkg::OUT_DATA_W-1:0]    out_tdata,
  // degenerate
  output logic [0:0]                        out_tuser
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = 2 * COORD_BITS + 2;
  localparam int MB  = tfn_pkg::M_BITS;
  localparam int SQW = 2 * MB;
  localparam int SW  = 2 * MB + 2;
  localparam int DW  = 2 * F + 67;
  localparam int FW  = tfn_pkg::FIELD_W;
  localparam int OW  = (F + 2 > FW) ? F + 2 : FW;
  localparam int NST = F + 9;
  localparam int RT0 = 7;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  logic signed [NW-1:0] n_w [3];
  logic [SW-1:0]        s_w [F+2];
  logic signed [DW-1:0] r_w [F+2][3];
  logic signed [DW-1:0] d_w [F+2][3];
  logic signed [DW-1:0] p_w [F+2][3];
  logic [F:0]           q_w [F+2][3];
  logic [2:0]           neg_w [F+2];
  logic                 dg_w  [F+2];
  logic [SQW-1:0]       sq_w  [3];
  logic signed [DW-1:0] s_ext;

  logic [FW-1:0] nrm_r [3];
  logic          dg_r;

  // ready runs back from the output: a stage loads if empty or draining
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];

  tfn_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk     (clk),
    .ld      (rdy[2:0]),
    .in_data (in_tdata),
    .n_out   (n_w)
  );

  tfn_norm #(
    .COORD_BITS (COORD_BITS)
  ) u_norm (
    .clk       (clk),
    .ld        (rdy[6:3]),
    .n_in      (n_w),
    .s_out     (s_w[0]),
    .sq_out    (sq_w),
    .neg_out   (neg_w[0]),
    .degen_out (dg_w[0])
  );

  // quotient start: q = 0, d = -1, so d^2*s = s and d*s = -s
  always_comb begin
    s_ext = $signed(DW'(s_w[0]));
    for (int i = 0; i < 3; i++) begin
      r_w[0][i] = $signed(DW'(sq_w[i]) << (2 * F + 2));
      d_w[0][i] = s_ext;
      p_w[0][i] = -s_ext;
      q_w[0][i] = '0;
    end
  end

  // one stage per quotient bit, top bit first
  for (genvar j = 0; j <= F; j++) begin : g_root
    tfn_root_step #(
      .FRAC_BITS (F),
      .BIT       (F - j)
    ) u_step (
      .clk       (clk),
      .ld        (rdy[RT0+j]),
      .s_in      (s_w[j]),
      .r_in      (r_w[j]),
      .d_in      (d_w[j]),
      .p_in      (p_w[j]),
      .q_in      (q_w[j]),
      .neg_in    (neg_w[j]),
      .degen_in  (dg_w[j]),
      .s_out     (s_w[j+1]),
      .r_out     (r_w[j+1]),
      .d_out     (d_w[j+1]),
      .p_out     (p_w[j+1]),
      .q_out     (q_w[j+1]),
      .neg_out   (neg_w[j+1]),
      .degen_out (dg_w[j+1])
    );
  end

  // output register: sign, degenerate override
  always_ff @(posedge clk) begin
    logic signed [OW-1:0] qv;
    logic signed [OW-1:0] res;
    if (rdy[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        qv       = $signed(OW'(q_w[F+1][i]));
        res      = neg_w[F+1][i] ? -qv : qv;
        nrm_r[i] <= dg_w[F+1] ? '0 : res[FW-1:0];
      end
      dg_r <= dg_w[F+1];
    end
  end

  assign out_tdata    = {nrm_r[2], nrm_r[1], nrm_r[0]};
  assign out_tuser[0] = dg_r;

  // degenerate beats carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate beat with nonzero normal");

  // an empty output stage lets the whole ready chain open
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  // a result only appears after the last quotient stage held one
  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[NST-2]))
    else $error("output valid without a preceding stage");

endmodule

// ===== tb/triangle_face_normal_core_test.sv =====
// self-checking testbench for the triangle face normal pipeline
`timescale 1ns / 100ps

module triangle_face_normal_core_test;

  localparam int FRAC      = tfn_pkg::FRAC_BITS_DEF;
  localparam int LIMIT_CYC = 400000;
  localparam int DRAIN_CYC = 60;

  typedef logic signed [tfn_pkg::FIELD_W-1:0] coord_t;
  typedef coord_t tri_t [tfn_pkg::IN_FIELDS];

  typedef struct {
    logic signed [tfn_pkg::FIELD_W-1:0] nx;
    logic signed [tfn_pkg::FIELD_W-1:0] ny;
    logic signed [tfn_pkg::FIELD_W-1:0] nz;
    logic                               degen;
  } normal_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tfn_pkg::IN_DATA_W-1:0]  in_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tfn_pkg::OUT_DATA_W-1:0] out_tdata;  // normal_x, normal_y, normal_z
  logic [0:0]                     out_tuser;  // degenerate

  normal_t normals_due[$];
  int      errors;
  int      cycles;
  int      send_idle_pct;
  int      recv_stall_pct;

  triangle_face_normal_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // unit normal of one triangle, rounded to Q1.FRAC
  function automatic normal_t face_normal(input tri_t t);
    longint      e1 [3];
    longint      e2 [3];
    longint      n [3];
    logic [63:0] m [3];
    logic [127:0] s;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0] q;
    logic [63:0] cand;
    logic [63:0] d;
    logic [15:0] o [3];
    int          k;
    normal_t     r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t[3+i]) - longint'(t[i]);
      e2[i] = longint'(t[6+i]) - longint'(t[3+i]);
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.nx = '0;
      r.ny = '0;
      r.nz = '0;
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) m[i] = (n[i] < 0) ? -n[i] : n[i];
    k = 0;
    while (((m[0] | m[1] | m[2]) >> k) >= (64'd1 << tfn_pkg::M_BITS)) k++;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      s += 128'(m[i]) * 128'(m[i]);
    end
    // bitwise search for the largest q with q - 1/2 <= m * 2^F / sqrt(s)
    for (int i = 0; i < 3; i++) begin
      q = '0;
      rhs = (128'(m[i]) * 128'(m[i])) << (2 * FRAC + 2);
      for (int b = FRAC; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        d = 2 * cand - 1;
        lhs = 128'(d) * 128'(d) * s;
        if (cand <= (64'd1 << FRAC) && lhs <= rhs) q = cand;
      end
      o[i] = (n[i] < 0) ? 16'(-q) : 16'(q);
    end
    r.nx = o[0];
    r.ny = o[1];
    r.nz = o[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // drive one triangle beat, idling first at the sender rate
  task automatic send_tri(input tri_t t);
    logic [tfn_pkg::IN_DATA_W-1:0] packed_tri;
    for (int i = 0; i < tfn_pkg::IN_FIELDS; i++)
      packed_tri[i*tfn_pkg::FIELD_W +: tfn_pkg::FIELD_W] = t[i];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= packed_tri;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    normals_due.insert(normals_due.size(), face_normal(t));
    @(negedge clk);
  endtask

  task automatic send_vertices(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    tri_t t;
    t = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
          coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    send_tri(t);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (cycles < 20) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (normals_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = normals_due.pop_front();
        if (out_tdata[15:0] !== want.nx || out_tdata[31:16] !== want.ny ||
            out_tdata[47:32] !== want.nz || out_tuser[0] !== want.degen) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     want.nx, want.ny, want.nz, want.degen,
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]),
                     $signed(out_tdata[47:32]), out_tuser[0]);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // corners, axis-aligned faces, degenerate and tiny triangles
  task automatic test_directed();
    send_vertices(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vertices(5, -7, 9, 5, -7, 9, 5, -7, 9);
    send_vertices(0, 0, 0, 256, 0, 0, 256, 256, 0);
    send_vertices(0, 0, 0, 256, 256, 0, 256, 0, 0);
    send_vertices(0, 0, 0, 0, 256, 0, 0, 256, 256);
    send_vertices(0, 0, 0, 0, 0, 256, 256, 0, 256);
    send_vertices(-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768);
    send_vertices(32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767);
    send_vertices(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768);
    send_vertices(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
    send_vertices(0, 0, 0, 1, 2, 3, 2, 4, 6);
    send_vertices(-32768, 0, 0, 0, 0, 0, 32767, 0, 0);
    send_vertices(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_vertices(0, 0, 0, 1, 0, 0, 1, 0, 1);
    send_vertices(100, 100, 100, 101, 100, 100, 100, 100, 101);
    send_vertices(0, 0, 0, 1, 1, 1, 1, -1, 0);
    send_vertices(-1, -1, -1, -1, -1, -1, 7, 3, 5);
    send_vertices(32767, 32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768);
  endtask

  // random triangles: wide, small, and collinear or coincident
  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    tri_t t;
    int   kind;
    int   sc;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      kind = $urandom_range(9);
      for (int i = 0; i < tfn_pkg::IN_FIELDS; i++) t[i] = coord_t'($urandom);
      if (kind < 3) begin
        for (int i = 3; i < tfn_pkg::IN_FIELDS; i++)
          t[i] = coord_t'(int'(t[i%3]) + $signed($urandom_range(64)) - 32);
      end else if (kind == 3) begin
        for (int i = 0; i < 3; i++) begin
          t[i] = coord_t'($signed($urandom_range(2000)) - 1000);
          sc = $signed($urandom_range(200)) - 100;
          t[3+i] = coord_t'(int'(t[i]) + sc);
          t[6+i] = coord_t'(int'(t[3+i]) + 2 * sc);
        end
      end else if (kind == 4) begin
        for (int i = 0; i < 3; i++) t[6+i] = t[$urandom_range(1) * 3 + i];
      end
      send_tri(t);
    end
    in_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b1;
    errors         = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(160, 0, 0);
    test_random(160, 60, 0);
    test_random(160, 0, 60);
    test_random(160, 37, 37);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && normals_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
